// File: sv/sorted_set_insert_engine_defines.svh
// ----------------------------------------------------------------------------
// Sorted set insert engine: assertion macros
// Shared assertion wrappers, clocked on clk_i; SSE_ASSERT uses reset as the disable.
// ----------------------------------------------------------------------------
`ifndef SORTED_SET_INSERT_ENGINE_DEFINES_SVH
`define SORTED_SET_INSERT_ENGINE_DEFINES_SVH

// Assertion that is checked only while the block is out of reset.
`define SSE_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Assertion that is checked on every clock edge, reset included.
`define SSE_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// File: sv/sse_pkg.sv
// ----------------------------------------------------------------------------
// Sorted set insert engine package
// Shared types, codes and helper functions for the engine and its cells.
// ----------------------------------------------------------------------------
package sse_pkg;

  // Default number of storage cells.
  localparam int unsigned SSE_CAPACITY = 64;

  localparam logic [63:0] SIGN_BIT = 64'h8000_0000_0000_0000;
  localparam logic [63:0] MAG_MASK = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] EXP_ONES = 64'h7FF0_0000_0000_0000;

  // Operation codes.
  typedef enum logic {
    FUNC_ADD  = 1'b0,
    FUNC_READ = 1'b1
  } func_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_DUPLICATE = 3'd1,
    ST_FULL      = 3'd2,
    ST_RANGE     = 3'd3,
    ST_NAN       = 3'd4
  } status_e;

  // Configuration register indexes.
  typedef enum logic {
    REG_KEEP_SORTED     = 1'b0,
    REG_DROP_DUPLICATES = 1'b1
  } reg_e;

  // Controller state.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SWEEP,
    ST_DONE
  } state_e;

  // Request data broadcast from the controller to every cell.
  typedef struct packed {
    logic [63:0] key;
    logic [63:0] value;
    logic [5:0]  index;
    logic        commit;
  } bcast_t;

  // True for any NaN pattern.
  function automatic logic is_nan(logic [63:0] v);
    return (v & MAG_MASK) > EXP_ONES;
  endfunction

  // Unsigned key whose order is numeric order; both zeros map to one key.
  function automatic logic [63:0] order_key(logic [63:0] v);
    logic [63:0] w;
    w = ((v & MAG_MASK) == 64'd0) ? 64'd0 : v;
    return w[63] ? ~w : (w | SIGN_BIT);
  endfunction

endpackage

// File: sv/sse_cell.sv
// ----------------------------------------------------------------------------
// Sorted set insert engine: storage cell
// Holds one entry, compares it with the broadcast key, passes duplicate,
// insert position and read carries to its upper neighbor, and takes part in
// the insert shift.
// ----------------------------------------------------------------------------
module sse_cell import sse_pkg::*; #(
  parameter int unsigned INDEX = 0,
  parameter int unsigned CNT_W = 7
) (
  input  logic             clk_i,
  input  bcast_t           bcast_i,
  input  logic [CNT_W-1:0] count_i,
  input  logic [CNT_W-1:0] ins_pos_i,
  input  logic [63:0]      prev_entry_i,
  input  logic [CNT_W-1:0] prev_pos_i,
  input  logic             prev_dup_i,
  input  logic [63:0]      prev_rd_i,
  output logic [63:0]      entry_o,
  output logic [CNT_W-1:0] pos_o,
  output logic             dup_o,
  output logic [63:0]      rd_o
);

  logic [63:0]      entry_q;
  logic [CNT_W-1:0] pos_q;
  logic             dup_q;
  logic [63:0]      rd_q;
  logic             valid;
  logic [63:0]      own_key;
  logic             le;
  logic             eq;
  logic             take_new;
  logic             take_prev;
  logic             sel;

  // Local compare of the stored entry against the request key.
  always_comb begin
    valid     = 32'(count_i) > INDEX;
    own_key   = order_key(entry_q);
    le        = own_key <= bcast_i.key;
    eq        = own_key == bcast_i.key;
    // The new value lands at the insert position; cells above it shift up.
    take_new  = 32'(ins_pos_i) == INDEX;
    take_prev = 32'(ins_pos_i) < INDEX;
    sel       = 32'(bcast_i.index) == INDEX;
  end

  // Entry store: the new value lands at the insert position and every cell
  // above it takes its lower neighbor's entry.
  always_ff @(posedge clk_i) begin
    if (bcast_i.commit) begin
      if (take_new) begin
        entry_q <= bcast_i.value;
      end else if (take_prev) begin
        entry_q <= prev_entry_i;
      end
    end
  end

  // Carries that ripple up the row one cell per cycle. The position carry
  // ends up one above the highest stored entry that is not above the key.
  always_ff @(posedge clk_i) begin
    pos_q <= (valid && le) ? CNT_W'(INDEX + 1) : prev_pos_i;
    dup_q <= prev_dup_i | (valid & eq);
    rd_q  <= sel ? entry_q : prev_rd_i;
  end

  assign entry_o = entry_q;
  assign pos_o   = pos_q;
  assign dup_o   = dup_q;
  assign rd_o    = rd_q;

endmodule

// File: sv/sorted_set_insert_engine.sv
// A request's result is valid once the duplicate, position and read carries
// have rippled through the row of CAPACITY cells at one cell per cycle. A new
// request is taken only after the last result has been loaded into the output
// register. Reset clears the count, the registers and the handshake state at
// once; the entry cells hold no reset and need no clearing.
// ----------------------------------------------------------------------------
// Sorted set insert engine
// Bounded set of double values kept in a row of cells, with sorted insert,
// optional duplicate removal and indexed read.
// ----------------------------------------------------------------------------
`include "sorted_set_insert_engine_defines.svh"

module sorted_set_insert_engine import sse_pkg::*; #(
  parameter int unsigned CAPACITY = SSE_CAPACITY
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Configuration write port.
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic        cfg_wdata_i,
  // Request stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [71:0] s_axis_tdata,  // [63:0] value, [69:64] index, [71:70] zero
  input  logic        s_axis_tuser,  // [0] func
  // Result stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [79:0] m_axis_tdata   // [2:0] status, [66:3] read_value,
                                     // [73:67] count, [79:74] zero
);

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);
  localparam int unsigned SWP_W = $clog2(CAPACITY);

  state_e            state_q, state_d;
  logic [SWP_W-1:0]  sweep_q, sweep_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic              keep_sorted_q;
  logic              drop_dup_q;
  logic              func_q;
  logic              nan_q;
  logic [63:0]       value_q;
  logic [63:0]       key_q;
  logic [5:0]        index_q;
  logic              out_valid_q;
  logic [2:0]        out_status_q;
  logic [63:0]       out_rd_q;
  logic [6:0]        out_count_q;
  logic              accept;
  logic              load;
  logic              commit;
  logic [2:0]        status;
  logic [63:0]       rd_val;
  logic [CNT_W-1:0]  ins_pos;
  bcast_t            bcast;

  logic [63:0]      entry [CAPACITY];
  logic [CNT_W-1:0] pos   [CAPACITY];
  logic             dup   [CAPACITY];
  logic [63:0]      rd    [CAPACITY];

  assign accept = s_axis_tvalid && s_axis_tready;

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      keep_sorted_q <= 1'b0;
      drop_dup_q    <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (reg_e'(cfg_addr_i))
        REG_KEEP_SORTED:     keep_sorted_q <= cfg_wdata_i;
        REG_DROP_DUPLICATES: drop_dup_q    <= cfg_wdata_i;
        default:             ;
      endcase
    end
  end

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      func_q  <= s_axis_tuser;
      value_q <= s_axis_tdata[63:0];
      key_q   <= order_key(s_axis_tdata[63:0]);
      nan_q   <= is_nan(s_axis_tdata[63:0]);
      index_q <= s_axis_tdata[69:64];
    end
  end

  // Result decision from the carries at the top of the row.
  always_comb begin
    status = ST_OK;
    rd_val = 64'd0;
    commit = 1'b0;
    cnt_d  = cnt_q;
    if (func_q == FUNC_READ) begin
      if (32'(index_q) >= 32'(cnt_q)) begin
        status = ST_RANGE;
      end else begin
        rd_val = rd[CAPACITY-1];
      end
    end else if (nan_q) begin
      status = ST_NAN;
    end else if (drop_dup_q && dup[CAPACITY-1]) begin
      status = ST_DUPLICATE;
    end else if (32'(cnt_q) >= CAPACITY) begin
      status = ST_FULL;
    end else begin
      commit = 1'b1;
      cnt_d  = cnt_q + CNT_W'(1);
    end
  end

  // Controller: next state and handshake outputs.
  always_comb begin
    state_d       = state_q;
    sweep_d       = sweep_q;
    load          = 1'b0;
    s_axis_tready = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        s_axis_tready = 1'b1;
        sweep_d       = '0;
        if (s_axis_tvalid) begin
          state_d = ST_SWEEP;
        end
      end
      ST_SWEEP: begin
        if (sweep_q == SWP_W'(CAPACITY - 1)) begin
          state_d = ST_DONE;
          sweep_d = '0;
        end else begin
          sweep_d = sweep_q + SWP_W'(1);
        end
      end
      ST_DONE: begin
        if (!out_valid_q || m_axis_tready) begin
          load    = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      sweep_q <= '0;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      sweep_q <= sweep_d;
      if (load) begin
        cnt_q <= cnt_d;
      end
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_status_q <= status;
      out_rd_q     <= rd_val;
      out_count_q  <= 7'(cnt_d);
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_count_q, out_rd_q, out_status_q};

  // Broadcast to the cells. In sorted mode the new value goes after every
  // stored entry that is not above it; otherwise it is appended.
  always_comb begin
    bcast.key    = key_q;
    bcast.value  = value_q;
    bcast.index  = index_q;
    bcast.commit = load && commit;
    ins_pos      = keep_sorted_q ? pos[CAPACITY-1] : cnt_q;
  end

  // Row of cells.
  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    logic [63:0]      prev_entry;
    logic [CNT_W-1:0] prev_pos;
    logic             prev_dup;
    logic [63:0]      prev_rd;
    if (g == 0) begin : g_first
      assign prev_entry = 64'd0;
      assign prev_pos   = '0;
      assign prev_dup   = 1'b0;
      assign prev_rd    = 64'd0;
    end else begin : g_next
      assign prev_entry = entry[g-1];
      assign prev_pos   = pos[g-1];
      assign prev_dup   = dup[g-1];
      assign prev_rd    = rd[g-1];
    end
    sse_cell #(
      .INDEX (g),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk_i        (clk_i),
      .bcast_i      (bcast),
      .count_i      (cnt_q),
      .ins_pos_i    (ins_pos),
      .prev_entry_i (prev_entry),
      .prev_pos_i   (prev_pos),
      .prev_dup_i   (prev_dup),
      .prev_rd_i    (prev_rd),
      .entry_o      (entry[g]),
      .pos_o        (pos[g]),
      .dup_o        (dup[g]),
      .rd_o         (rd[g])
    );
  end

  // Checks on the controller and the entry count.
  `SSE_ASSERT(a_cnt_bound, 32'(cnt_q) <= CAPACITY, "entry count above capacity")
  `SSE_ASSERT(a_cnt_step, (load && commit) |=> (cnt_q == $past(cnt_q) + CNT_W'(1)), "bad count")
  `SSE_ASSERT(a_idle_sweep, (state_q == ST_IDLE) |-> (sweep_q == '0), "sweep not cleared")
  `SSE_ASSERT_ALWAYS(a_ready_idle, s_axis_tready |-> (state_q == ST_IDLE), "ready while busy")

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// Sorted set insert engine testbench
// Drives add and read requests into the engine under several register
// settings and checks each result against a predictor of the store or a fixed row.
// A short directed table comes first, then random phases that fill the
// store, with random idling on both streams and one long output hold-off.
// ----------------------------------------------------------------------------
module tb_top;
  import sse_pkg::*;

  localparam int unsigned CAPACITY       = SSE_CAPACITY;
  localparam int          HALF_PERIOD    = 5;
  localparam int          RESET_CYCLES   = 12;
  localparam int          PHASE_ITEMS    = 330;
  localparam int          PHASE_COUNT    = 6;
  localparam int          RANDOM_ITEMS   = PHASE_ITEMS * PHASE_COUNT;
  localparam int          RX_HOLD_CYCLES = 600;
  // The longest quiet stretch is the output hold-off plus one request in flight,
  // taken several times over.
  localparam int          WATCHDOG_LIMIT = 4 * (RX_HOLD_CYCLES + CAPACITY + 100);

  // One result of the engine, split into its fields.
  typedef struct packed {
    status_e     status;
    logic [63:0] read_value;
    logic [6:0]  count;
  } set_result_t;

  // One row of the directed stimulus: a register write or a request.
  typedef struct packed {
    bit          is_cfg;
    reg_e        cfg_reg;
    logic        cfg_val;
    func_e       func;
    logic [63:0] value;
    logic [5:0]  index;
    bit          is_fixed;
    set_result_t fixed;
  } stim_row_t;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_addr_i;
  logic        cfg_wdata_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [71:0] s_axis_tdata;   // [63:0] value, [69:64] index, [71:70] zero
  logic        s_axis_tuser;   // [0] func
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [79:0] m_axis_tdata;   // [2:0] status, [66:3] read_value, [73:67] count

  // Predicted contents of the store and the register copies.
  logic [63:0] held_values [CAPACITY];
  int          held_count;
  logic        sorted_mode;
  logic        drop_dups;

  set_result_t pending_results [$];
  int          failure_count;
  int          tx_idle_pct;
  int          rx_idle_pct;
  int          hold_requests;
  int          quiet_cycles;

  sorted_set_insert_engine #(
    .CAPACITY(CAPACITY)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_addr_i   (cfg_addr_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // Free-running clock.
  initial clk_i = 1'b0;
  always #HALF_PERIOD clk_i = ~clk_i;

  // A NaN has an all-ones exponent and a nonzero fraction.
  function automatic bit is_nan_pattern(logic [63:0] p);
    return (p[62:52] == 11'h7FF) && (p[51:0] != 52'd0);
  endfunction

  // Unsigned key ordered like the numbers; both zeros share one key.
  function automatic logic [63:0] numeric_key(logic [63:0] p);
    if (p[62:0] == 63'd0) return {1'b1, 63'd0};
    if (p[63]) return ~p;
    return {1'b1, p[62:0]};
  endfunction

  // Applies one request to the predicted store and returns its result.
  function automatic set_result_t apply_request(func_e f, logic [63:0] v, logic [5:0] idx);
    set_result_t r;
    logic [63:0] k;
    bit          dup;
    int          pos;
    int          i;
    r.status     = ST_OK;
    r.read_value = '0;
    if (f == FUNC_READ) begin
      if (int'(idx) < held_count) r.read_value = held_values[idx];
      else r.status = ST_RANGE;
    end else if (is_nan_pattern(v)) begin
      r.status = ST_NAN;
    end else begin
      k   = numeric_key(v);
      dup = 1'b0;
      for (i = 0; i < held_count; i++)
        if (numeric_key(held_values[i]) == k) dup = 1'b1;
      if (drop_dups && dup) begin
        r.status = ST_DUPLICATE;
      end else if (held_count >= CAPACITY) begin
        r.status = ST_FULL;
      end else begin
        // Equal values go after every stored equal one.
        pos = held_count;
        if (sorted_mode) begin
          pos = 0;
          for (i = 0; i < held_count; i++)
            if (numeric_key(held_values[i]) <= k) pos = i + 1;
        end
        for (i = held_count; i > pos; i--) held_values[i] = held_values[i - 1];
        held_values[pos] = v;
        held_count++;
      end
    end
    r.count = held_count[6:0];
    return r;
  endfunction

  function automatic stim_row_t cfg_row(reg_e r, logic v);
    stim_row_t row;
    row         = '0;
    row.is_cfg  = 1'b1;
    row.cfg_reg = r;
    row.cfg_val = v;
    return row;
  endfunction

  function automatic stim_row_t req_row(func_e f, logic [63:0] v, logic [5:0] idx);
    stim_row_t row;
    row       = '0;
    row.func  = f;
    row.value = v;
    row.index = idx;
    return row;
  endfunction

  // Request whose result is written out in the row itself.
  function automatic stim_row_t fixed_row(func_e f, logic [63:0] v, logic [5:0] idx,
                                          status_e s, logic [63:0] rd, logic [6:0] c);
    stim_row_t row;
    row                  = req_row(f, v, idx);
    row.is_fixed         = 1'b1;
    row.fixed.status     = s;
    row.fixed.read_value = rd;
    row.fixed.count      = c;
    return row;
  endfunction

  function automatic logic [63:0] random_nan();
    logic [51:0] frac;
    frac = {20'($urandom), 32'($urandom)};
    if (frac == 52'd0) frac = 52'd1;
    return {1'($urandom_range(1)), 11'h7FF, frac};
  endfunction

  // A value that is probably not stored yet: raw bits, a special or a neighbor.
  function automatic logic [63:0] fresh_value();
    logic [63:0] p;
    p = {$urandom, $urandom};
    case ($urandom_range(3))
      2: begin
        case ($urandom_range(7))
          0: p = 64'h0000_0000_0000_0000;
          1: p = 64'h8000_0000_0000_0000;
          2: p = 64'h7FF0_0000_0000_0000;
          3: p = 64'hFFF0_0000_0000_0000;
          4: p = 64'h3FF0_0000_0000_0000;
          5: p = 64'hBFF0_0000_0000_0000;
          6: p = 64'h0000_0000_0000_0001;
          default: p = 64'h7FEF_FFFF_FFFF_FFFF;
        endcase
      end
      3: begin
        if (held_count > 0) p = held_values[$urandom_range(held_count - 1)] ^ 64'd1;
      end
      default: ;
    endcase
    return p;
  endfunction

  // A copy of a stored value, with the zero sign flipped now and then.
  function automatic logic [63:0] stored_copy();
    logic [63:0] p;
    p = held_values[$urandom_range(held_count - 1)];
    if (p[62:0] == 63'd0 && $urandom_range(1) == 1) p[63] = ~p[63];
    return p;
  endfunction

  // Random request; new values are only added while below fill_limit.
  task automatic make_random_request(output func_e f, output logic [63:0] v,
                                     output logic [5:0] idx, input int fill_limit);
    int roll;
    bit room;
    idx  = 6'($urandom_range(63));
    v    = {$urandom, $urandom};
    roll = $urandom_range(99);
    f    = FUNC_ADD;
    room = (held_count < fill_limit) || (held_count >= CAPACITY);
    if (roll < 40) begin
      f = FUNC_READ;
      if (held_count > 0 && $urandom_range(99) < 85) idx = 6'($urandom_range(held_count - 1));
    end else begin
      roll = $urandom_range(99);
      if (roll < 15) begin
        v = random_nan();
      end else if (!room && !drop_dups) begin
        // Every non-NaN add would grow the store here.
        if ($urandom_range(99) < 30) v = random_nan();
        else f = FUNC_READ;
      end else if (held_count > 0 && (roll < 50 || !room)) begin
        v = stored_copy();
      end else begin
        v = fresh_value();
      end
    end
  endtask

  // Offers one request and records its expected result once accepted.
  task automatic send_request(input func_e f, input logic [63:0] v, input logic [5:0] idx,
                              input bit use_fixed, input set_result_t fixed);
    set_result_t predicted;
    while ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {2'b00, idx, v};
    s_axis_tuser  <= f;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(f, v, idx);
    pending_results.push_back(use_fixed ? fixed : predicted);
  endtask

  // Stops offering and waits until every expected result has arrived.
  task automatic quiesce();
    if (s_axis_tvalid) s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_register(input reg_e r, input logic v);
    cfg_addr_i  <= r;
    cfg_wdata_i <= v;
    cfg_we_i    <= 1'b1;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    if (r == REG_KEEP_SORTED) sorted_mode = v;
    else drop_dups = v;
    @(posedge clk_i);
  endtask

  // Stimulus: reset, directed table, then the random phases.
  initial begin : stimulus
    stim_row_t   directed_rows [$];
    set_result_t no_fixed;
    func_e       f;
    logic [63:0] v;
    logic [5:0]  idx;
    int          fill_limit;
    int          random_sent;
    logic        ph_sorted;
    logic        ph_dedup;

    cfg_we_i      <= 1'b0;
    cfg_addr_i    <= 1'b0;
    cfg_wdata_i   <= 1'b0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    s_axis_tuser  <= 1'b0;
    rst_ni        <= 1'b0;
    held_count    = 0;
    sorted_mode   = 1'b0;
    drop_dups     = 1'b0;
    failure_count = 0;
    hold_requests = 0;
    tx_idle_pct   = 24;
    rx_idle_pct   = 67;
    no_fixed      = '0;
    random_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty store, NaN forms, zeros, infinities, equal values, both modes.
    directed_rows.push_back(fixed_row(FUNC_READ, 64'd0, 6'd0, ST_RANGE, 64'd0, 7'd0));
    directed_rows.push_back(fixed_row(FUNC_READ, '1, 6'd63, ST_RANGE, 64'd0, 7'd0));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'h7FF8_0000_0000_0000, 6'd0,
                                      ST_NAN, 64'd0, 7'd0));
    directed_rows.push_back(fixed_row(FUNC_ADD, '1, 6'd63, ST_NAN, 64'd0, 7'd0));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'h7FF0_0000_0000_0001, 6'd0,
                                      ST_NAN, 64'd0, 7'd0));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'h7FF0_0000_0000_0000, 6'd0,
                                      ST_OK, 64'd0, 7'd1));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'd0, 6'd63, ST_OK, 64'd0, 7'd2));
    directed_rows.push_back(fixed_row(FUNC_READ, 64'd0, 6'd0, ST_OK,
                                      64'h7FF0_0000_0000_0000, 7'd2));
    directed_rows.push_back(fixed_row(FUNC_READ, 64'd0, 6'd1, ST_OK, 64'd0, 7'd2));
    directed_rows.push_back(fixed_row(FUNC_READ, 64'd0, 6'd2, ST_RANGE, 64'd0, 7'd2));
    directed_rows.push_back(cfg_row(REG_DROP_DUPLICATES, 1'b1));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'h8000_0000_0000_0000, 6'd0,
                                      ST_DUPLICATE, 64'd0, 7'd2));
    directed_rows.push_back(fixed_row(FUNC_ADD, 64'h7FF0_0000_0000_0000, 6'd0,
                                      ST_DUPLICATE, 64'd0, 7'd2));
    directed_rows.push_back(cfg_row(REG_KEEP_SORTED, 1'b1));
    directed_rows.push_back(req_row(FUNC_ADD, 64'hFFF0_0000_0000_0000, 6'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'h3FF0_0000_0000_0000, 6'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'h0000_0000_0000_0001, 6'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'hFFEF_FFFF_FFFF_FFFF, 6'd0));
    directed_rows.push_back(cfg_row(REG_DROP_DUPLICATES, 1'b0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'h3FF0_0000_0000_0000, 6'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'h8000_0000_0000_0000, 6'd0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'h7FEF_FFFF_FFFF_FFFF, 6'd0));
    directed_rows.push_back(req_row(FUNC_READ, 64'd0, 6'd0));
    directed_rows.push_back(req_row(FUNC_READ, 64'd0, 6'd5));
    directed_rows.push_back(req_row(FUNC_READ, 64'd0, 6'd8));
    directed_rows.push_back(cfg_row(REG_KEEP_SORTED, 1'b0));
    directed_rows.push_back(req_row(FUNC_ADD, 64'hBFF0_0000_0000_0000, 6'd0));
    directed_rows.push_back(req_row(FUNC_READ, 64'd0, 6'd9));

    foreach (directed_rows[i]) begin
      if (directed_rows[i].is_cfg) begin
        quiesce();
        write_register(directed_rows[i].cfg_reg, directed_rows[i].cfg_val);
      end else begin
        send_request(directed_rows[i].func, directed_rows[i].value, directed_rows[i].index,
                     directed_rows[i].is_fixed, directed_rows[i].fixed);
      end
    end

    // Random phases; the store fills step by step and ends up full.
    for (int ph = 0; ph < PHASE_COUNT; ph++) begin
      case (ph)
        0: begin ph_sorted = 1'b1; ph_dedup = 1'b1; fill_limit = 22; end
        1: begin ph_sorted = 1'b1; ph_dedup = 1'b0; fill_limit = 32; end
        2: begin ph_sorted = 1'b0; ph_dedup = 1'b1; fill_limit = 42; end
        3: begin ph_sorted = 1'b0; ph_dedup = 1'b0; fill_limit = 52; end
        4: begin ph_sorted = 1'b1; ph_dedup = 1'b0; fill_limit = CAPACITY; end
        default: begin ph_sorted = 1'b1; ph_dedup = 1'b1; fill_limit = CAPACITY; end
      endcase
      quiesce();
      write_register(REG_KEEP_SORTED, ph_sorted);
      write_register(REG_DROP_DUPLICATES, ph_dedup);
      // Long output hold-off so that the engine stalls its input.
      if (ph == 3) hold_requests++;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        case (random_sent * 3 / RANDOM_ITEMS)
          0: begin tx_idle_pct = 24; rx_idle_pct = 67; end
          1: begin tx_idle_pct = 67; rx_idle_pct = 24; end
          default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
        endcase
        // Sender pauses until the engine has returned everything.
        if (ph == 1 && n == PHASE_ITEMS / 2) quiesce();
        make_random_request(f, v, idx, fill_limit);
        send_request(f, v, idx, 1'b0, no_fixed);
        random_sent++;
      end
    end

    quiesce();
    repeat (CAPACITY + 4) @(posedge clk_i);
    if (failure_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Result side: random ready, one long hold-off on request, field checks.
  initial begin : result_sink
    int          hold_left;
    int          holds_served;
    set_result_t want;
    status_e     got_status;
    logic [63:0] got_value;
    logic [6:0]  got_count;
    m_axis_tready <= 1'b0;
    hold_left    = 0;
    holds_served = 0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && m_axis_tvalid && m_axis_tready) begin
        got_status = status_e'(m_axis_tdata[2:0]);
        got_value  = m_axis_tdata[66:3];
        got_count  = m_axis_tdata[73:67];
        if (pending_results.size() == 0) begin
          $error("unexpected result: status %0d, read_value %h, count %0d",
                 got_status, got_value, got_count);
          failure_count++;
        end else begin
          want = pending_results.pop_front();
          if (got_status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, got_status);
            failure_count++;
          end
          if (got_value !== want.read_value) begin
            $error("read_value: expected %h, actual %h", want.read_value, got_value);
            failure_count++;
          end
          if (got_count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, got_count);
            failure_count++;
          end
        end
      end
      if (hold_requests != holds_served) begin
        holds_served++;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: ends the run when nothing moves on either stream for too long.
  initial quiet_cycles = 0;
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

endmodule
